// ===== design/rsc_pkg.sv =====
`default_nettype none

package rsc_pkg;

  localparam int VAL_W      = 64;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int NUM_COORDS = 4;

  // bits of quotient retired per divider cycle
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYC    = VAL_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_RD_SCAT  = 2'd2;
  localparam logic [1:0] OP_RD_CENT  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== design/running_scatter_covariance.sv =====
// Each scatter entry takes two passes through one shared divider that retires
// DIV_STEP quotient bits a cycle; centroid updates reuse it. Clears, count-full refusals
// and reads go straight to the response state; one item is in flight at a time.
// Reset: count zero, dimension 4, centroid zero, all scatter valid bits cleared
// so every scatter entry reads as zero; no clearing pass.
`default_nettype none

module running_scatter_covariance
  import rsc_pkg::*;
#(
  parameter int MAX_DIM    = 4,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [2:0]            cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            operation_i,
  input  wire logic signed [31:0]    coord_0_i,
  input  wire logic signed [31:0]    coord_1_i,
  input  wire logic signed [31:0]    coord_2_i,
  input  wire logic signed [31:0]    coord_3_i,
  input  wire logic [1:0]            row_index_i,
  input  wire logic [1:0]            col_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [63:0]         value_o,
  output logic [COUNT_BITS-1:0]      point_count_o,
  output logic [1:0]                 status_o
);

  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB    = COUNT_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROW  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_SMAG = 4'd5;
  localparam logic [3:0] S_DIV2 = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_CMAG = 4'd8;
  localparam logic [3:0] S_CDIV = 4'd9;
  localparam logic [3:0] S_CWR  = 4'd10;
  localparam logic [3:0] S_RESP = 4'd11;

  logic [3:0]                state_q, state_d;
  logic [CB-1:0]             cnt_q, cnt_d, n_q, n_d;
  logic [2:0]                dim_q, dim_d;
  logic [3:0]                i_q, i_d, j_q, j_d;
  logic signed [DIFF_W-1:0]  di_q, di_d;
  logic signed [DIFF_W-1:0]  d_q [MAX_DIM];
  logic signed [DIFF_W-1:0]  d_d [MAX_DIM];
  logic signed [COORD_W-1:0] c_q [MAX_DIM];
  logic signed [COORD_W-1:0] c_d [MAX_DIM];
  logic                      neg_q, neg_d, sat_q, sat_d;
  logic signed [VAL_W-1:0]   s_q, s_d;
  logic [CB-1:0]             div_rem_q, div_rem_d;
  logic [VAL_W-1:0]          div_quo_q, div_quo_d;
  logic [DIV_CNT_W-1:0]      div_cnt_q, div_cnt_d;
  logic [DEPTH-1:0]          vld_q, vld_d;
  logic                      rd_mem_q, rd_mem_d;
  logic signed [VAL_W-1:0]   res_val_q, res_val_d;
  logic [1:0]                res_st_q, res_st_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0]   out_val_q, out_val_d;
  logic [CB-1:0]             out_cnt_q, out_cnt_d;
  logic [1:0]                out_st_q, out_st_d;

  logic [VAL_W-1:0]          mem_q [DEPTH];
  logic [VAL_W-1:0]          rdata_q;
  logic                      rvld_q;
  logic                      mem_re, mem_we;
  logic [AW-1:0]             mem_ra, mem_wa;
  logic [VAL_W-1:0]          mem_wd;

  logic [3:0]                act_dim;
  logic                      in_acc, slot_free;
  logic signed [COORD_W-1:0] cin [NUM_COORDS];
  logic [CB-1:0]             div_rem_nx;
  logic [VAL_W-1:0]          div_quo_nx;

  assign cin[0] = coord_0_i;
  assign cin[1] = coord_1_i;
  assign cin[2] = coord_2_i;
  assign cin[3] = coord_3_i;

  assign act_dim = (dim_q == 3'd0) ? 4'd1 :
                   ({1'b0, dim_q} > 4'(MAX_DIM)) ? 4'(MAX_DIM) : {1'b0, dim_q};

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  function automatic logic [COORD_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] m;
    m = v[DIFF_W-1] ? -v : v;
    return m[COORD_W-1:0];
  endfunction

  // restoring divide, DIV_STEP bits per cycle
  always_comb begin
    logic [CB:0]      r;
    logic [VAL_W-1:0] qv;
    r  = {1'b0, div_rem_q};
    qv = div_quo_q;
    for (int k = 0; k < DIV_STEP; k++) begin
      r  = {r[CB-1:0], qv[VAL_W-1]};
      qv = {qv[VAL_W-2:0], 1'b0};
      if (r >= {1'b0, n_q}) begin
        r     = r - {1'b0, n_q};
        qv[0] = 1'b1;
      end
    end
    div_rem_nx = r[CB-1:0];
    div_quo_nx = qv;
  end

  always_comb begin
    logic [VAL_W-1:0]        q;
    logic signed [VAL_W-1:0] term, entry;
    logic signed [VAL_W:0]   sum;
    logic                    tsat;
    logic [3:0]              row4, col4;
    logic signed [COORD_W-1:0] cv;

    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    dim_d       = dim_q;
    i_d         = i_q;
    j_d         = j_q;
    di_d        = di_q;
    d_d         = d_q;
    c_d         = c_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    s_d         = s_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_cnt_d   = div_cnt_q;
    vld_d       = vld_q;
    rd_mem_d    = rd_mem_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_ra      = AW'(32'(i_q) * MAX_DIM + 32'(j_q));
    mem_wa      = AW'(32'(i_q) * MAX_DIM + 32'(j_q));
    mem_wd      = '0;
    q           = div_quo_q;
    term        = '0;
    entry       = '0;
    sum         = '0;
    tsat        = 1'b0;
    row4        = {2'b00, row_index_i};
    col4        = {2'b00, col_index_i};
    cv          = '0;

    if (cfg_valid_i) begin
      dim_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rd_mem_d  = 1'b0;
          res_val_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_RESP;
          case (operation_i)
            OP_ADD: begin
              if (&cnt_q) begin
                res_st_d = ST_FULL;
              end else begin
                cnt_d   = cnt_q + 1'b1;
                n_d     = cnt_q + 1'b1;
                i_d     = '0;
                j_d     = '0;
                sat_d   = 1'b0;
                state_d = S_ROW;
                for (int k = 0; k < MAX_DIM; k++) begin
                  cv     = (k < NUM_COORDS) ? cin[k] : '0;
                  d_d[k] = DIFF_W'(cv) - DIFF_W'(c_q[k]);
                end
              end
            end
            OP_CLEAR: begin
              vld_d = '0;
              cnt_d = '0;
              for (int k = 0; k < MAX_DIM; k++) begin
                c_d[k] = '0;
              end
            end
            OP_RD_SCAT: begin
              if (row4 >= act_dim || col4 >= act_dim) begin
                res_st_d = ST_RANGE;
              end else begin
                mem_re   = 1'b1;
                mem_ra   = AW'(32'(row4) * MAX_DIM + 32'(col4));
                rd_mem_d = 1'b1;
              end
            end
            default: begin
              if (row4 >= act_dim) begin
                res_st_d = ST_RANGE;
              end else begin
                res_val_d = VAL_W'(c_q[row4[DW-1:0]]);
              end
            end
          endcase
        end
      end
      S_ROW: begin
        di_d    = d_q[i_q[DW-1:0]];
        state_d = S_MUL;
      end
      S_MUL: begin
        div_quo_d = VAL_W'(mag33(di_q)) * VAL_W'(mag33(d_q[j_q[DW-1:0]]));
        div_rem_d = '0;
        div_cnt_d = '0;
        neg_d     = di_q[DIFF_W-1] ^ d_q[j_q[DW-1:0]][DIFF_W-1];
        mem_re    = 1'b1;
        state_d   = S_DIV1;
      end
      S_DIV1, S_DIV2, S_CDIV: begin
        div_rem_d = div_rem_nx;
        div_quo_d = div_quo_nx;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
          case (state_q)
            S_DIV1:  state_d = S_ADD;
            S_DIV2:  state_d = S_WR;
            default: state_d = S_CWR;
          endcase
        end
      end
      S_ADD: begin
        if (neg_q) begin
          if (q[VAL_W-1]) begin
            term = VAL_MIN;
            tsat = |q[VAL_W-2:0];
          end else begin
            term = -$signed(q);
          end
        end else if (q[VAL_W-1]) begin
          term = VAL_MAX;
          tsat = 1'b1;
        end else begin
          term = $signed(q);
        end
        entry = rvld_q ? $signed(rdata_q) : '0;
        sum   = {entry[VAL_W-1], entry} + {term[VAL_W-1], term};
        if (sum[VAL_W] != sum[VAL_W-1]) begin
          s_d  = sum[VAL_W] ? VAL_MIN : VAL_MAX;
          tsat = 1'b1;
        end else begin
          s_d = sum[VAL_W-1:0];
        end
        sat_d   = sat_q | tsat;
        state_d = S_SMAG;
      end
      S_SMAG: begin
        div_quo_d = s_q[VAL_W-1] ? VAL_W'(-s_q) : VAL_W'(s_q);
        div_rem_d = '0;
        div_cnt_d = '0;
        state_d   = S_DIV2;
      end
      S_WR: begin
        mem_we = 1'b1;
        mem_wd = s_q[VAL_W-1] ? VAL_W'(s_q + $signed(q)) : VAL_W'(s_q - $signed(q));
        vld_d[mem_wa] = 1'b1;
        if (j_q + 4'd1 == act_dim) begin
          j_d = '0;
          if (i_q + 4'd1 == act_dim) begin
            i_d     = '0;
            state_d = S_CMAG;
          end else begin
            i_d     = i_q + 4'd1;
            state_d = S_ROW;
          end
        end else begin
          j_d     = j_q + 4'd1;
          state_d = S_MUL;
        end
      end
      S_CMAG: begin
        div_quo_d = VAL_W'(mag33(d_q[i_q[DW-1:0]]));
        div_rem_d = '0;
        div_cnt_d = '0;
        state_d   = S_CDIV;
      end
      S_CWR: begin
        if (d_q[i_q[DW-1:0]][DIFF_W-1]) begin
          c_d[i_q[DW-1:0]] = c_q[i_q[DW-1:0]] - $signed(q[COORD_W-1:0]);
        end else begin
          c_d[i_q[DW-1:0]] = c_q[i_q[DW-1:0]] + $signed(q[COORD_W-1:0]);
        end
        if (i_q + 4'd1 == act_dim) begin
          res_val_d = '0;
          res_st_d  = sat_q ? ST_SAT : ST_OK;
          state_d   = S_RESP;
        end else begin
          i_d     = i_q + 4'd1;
          state_d = S_CMAG;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_val_d   = rd_mem_q ? (rvld_q ? $signed(rdata_q) : '0) : res_val_q;
          out_cnt_d   = cnt_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      dim_q       <= 3'd4;
      i_q         <= '0;
      j_q         <= '0;
      di_q        <= '0;
      neg_q       <= 1'b0;
      sat_q       <= 1'b0;
      s_q         <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      div_cnt_q   <= '0;
      vld_q       <= '0;
      rd_mem_q    <= 1'b0;
      res_val_q   <= '0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_cnt_q   <= '0;
      out_st_q    <= ST_OK;
      for (int k = 0; k < MAX_DIM; k++) begin
        d_q[k] <= '0;
        c_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      dim_q       <= dim_d;
      i_q         <= i_d;
      j_q         <= j_d;
      di_q        <= di_d;
      neg_q       <= neg_d;
      sat_q       <= sat_d;
      s_q         <= s_d;
      div_rem_q   <= div_rem_d;
      div_quo_q   <= div_quo_d;
      div_cnt_q   <= div_cnt_d;
      vld_q       <= vld_d;
      rd_mem_q    <= rd_mem_d;
      res_val_q   <= res_val_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_cnt_q   <= out_cnt_d;
      out_st_q    <= out_st_d;
      d_q         <= d_d;
      c_q         <= c_d;
    end
  end

  // scatter memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
      rvld_q  <= vld_q[mem_ra];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_val_q;
  assign point_count_o = out_cnt_q;
  assign status_o      = out_st_q;

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> &point_count_o)
    else $error("refused point without full count");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_RANGE |-> value_o == '0)
    else $error("out of range read returned data");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV1 || state_q == S_DIV2 || state_q == S_CDIV) |-> div_rem_q < n_q)
    else $error("divider remainder not below count");

endmodule

`default_nettype wire

// ===== bench/running_scatter_covariance_test.sv =====
`default_nettype none

module running_scatter_covariance_test
  import rsc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIMS = 4;
  localparam int CNT_W = 24;
  localparam int RANDOM_ITEMS = 1300;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic [1:0]         row;
    logic [1:0]         col;
  } point_beat_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [CNT_W-1:0]   count;
    logic [1:0]         status;
  } moment_beat_t;

  typedef struct {
    point_beat_t beat;
    bit          known;
    moment_beat_t want;
  } stim_row_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] op;
  logic signed [31:0] c0, c1, c2, c3;
  logic [1:0] row, col;
  logic out_valid, out_ready;
  logic signed [63:0] value;
  logic [CNT_W-1:0] count;
  logic [1:0] status;

  running_scatter_covariance uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op), .coord_0_i(c0), .coord_1_i(c1), .coord_2_i(c2), .coord_3_i(c3),
    .row_index_i(row), .col_index_i(col),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .value_o(value), .point_count_o(count), .status_o(status)
  );

  // predictor state
  logic signed [63:0] scat_m [DIMS*DIMS];
  logic signed [31:0] cent_m [DIMS];
  logic [CNT_W-1:0]   seen_m;
  logic [2:0]         dim_reg;

  moment_beat_t moments_due[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_recv = 0;
  int idle_watch = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                 logic signed [63:0] b, ref bit sat);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(VAL_MAX)) begin
      sat = 1;
      return VAL_MAX;
    end
    if (s < 65'(VAL_MIN)) begin
      sat = 1;
      return VAL_MIN;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] cross_term(logic signed [63:0] di,
      logic signed [63:0] dj, logic [63:0] n, ref bit sat);
    logic [127:0] m;
    m = (128'(mag(di)) * 128'(mag(dj))) / 128'(n);
    if ((di < 0) == (dj < 0)) begin
      if (m > 128'(VAL_MAX)) begin
        sat = 1;
        return VAL_MAX;
      end
      return m[63:0];
    end
    if (m > 128'h8000_0000_0000_0000) begin
      sat = 1;
      return VAL_MIN;
    end
    return -m[63:0];
  endfunction

  function automatic void clear_moments();
    foreach (scat_m[k]) scat_m[k] = '0;
    foreach (cent_m[k]) cent_m[k] = '0;
    seen_m = '0;
  endfunction

  function automatic moment_beat_t predict_moment(point_beat_t b);
    moment_beat_t r;
    int dim;
    logic signed [63:0] d [DIMS];
    logic signed [63:0] s, n;
    logic signed [31:0] x;
    bit sat;
    r = '0;
    sat = 0;
    dim = dim_reg == 0 ? 1 : (dim_reg > DIMS ? DIMS : int'(dim_reg));
    case (b.op)
      OP_ADD: begin
        if (seen_m == {CNT_W{1'b1}}) r.status = ST_FULL;
        else begin
          seen_m++;
          n = 64'(seen_m);
          for (int i = 0; i < dim; i++) begin
            x = i == 0 ? b.c0 : i == 1 ? b.c1 : i == 2 ? b.c2 : b.c3;
            d[i] = 64'(x) - 64'(cent_m[i]);
          end
          for (int i = 0; i < dim; i++)
            for (int j = 0; j < dim; j++) begin
              s = sat_sum(scat_m[i*DIMS+j], cross_term(d[i], d[j], n, sat), sat);
              scat_m[i*DIMS+j] = s - s / n;
            end
          for (int i = 0; i < dim; i++) cent_m[i] = 32'(64'(cent_m[i]) + d[i] / n);
          if (sat) r.status = ST_SAT;
        end
      end
      OP_CLEAR: clear_moments();
      OP_RD_SCAT: begin
        if (b.row >= dim || b.col >= dim) r.status = ST_RANGE;
        else r.value = scat_m[b.row*DIMS+b.col];
      end
      default: begin
        if (b.row >= dim) r.status = ST_RANGE;
        else r.value = 64'(cent_m[b.row]);
      end
    endcase
    r.count = seen_m;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side
  always @(posedge clk) begin
    moment_beat_t w;
    if (rst_n && out_valid && out_ready) begin
      if (moments_due.size() == 0) report_mismatch("unexpected beat", value, '0);
      else begin
        w = moments_due.pop_front();
        if (value !== w.value) report_mismatch("value", value, w.value);
        if (count !== w.count) report_mismatch("count", 64'(count), 64'(w.count));
        if (status !== w.status) report_mismatch("status", 64'(status), 64'(w.status));
      end
    end
    out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_watch <= 0;
    else idle_watch <= idle_watch + 1;
    if (idle_watch >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_point(point_beat_t b, bit known, moment_beat_t want);
    moment_beat_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      if (in_valid) in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {op, c0, c1, c2, c3, row, col} <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_moment(b);
    if (known && p !== want) report_mismatch("table row", p[89:26], want[89:26]);
    moments_due.push_back(p);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 0;
    while (moments_due.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_dim(logic [2:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dim_reg = v;
    cfg_valid <= 0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(4000))) - 2000 <<< 12;
    endcase
  endfunction

  function automatic point_beat_t rand_point();
    point_beat_t b;
    int pick;
    pick = $urandom_range(99);
    b.op = pick < 60 ? OP_ADD : pick < 63 ? OP_CLEAR : pick < 85 ? OP_RD_SCAT : OP_RD_CENT;
    b.c0 = rand_coord();
    b.c1 = rand_coord();
    b.c2 = rand_coord();
    b.c3 = rand_coord();
    b.row = 2'($urandom);
    b.col = 2'($urandom);
    return b;
  endfunction

  stim_row_t plan[$];

  function automatic void add_row(logic [1:0] o, logic signed [31:0] a, logic signed [31:0] b2,
      logic [1:0] r, logic [1:0] c, bit known, logic signed [63:0] v, int n,
      logic [1:0] st);
    stim_row_t s;
    s.beat = '{o, a, b2, a, b2, r, c};
    s.known = known;
    s.want = '{v, CNT_W'(n), st};
    plan.push_back(s);
  endfunction

  initial begin
    point_beat_t b;
    moment_beat_t none;
    int phase;
    none = '0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    in_valid = 0;
    {op, c0, c1, c2, c3, row, col} = '0;
    out_ready = 0;
    dim_reg = 3'd4;
    clear_moments();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    add_row(OP_RD_SCAT, 0, 0, 3, 3, 1, 0, 0, ST_OK);
    add_row(OP_RD_CENT, 0, 0, 2, 0, 1, 0, 0, ST_OK);
    add_row(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 1, 0, 1, ST_OK);
    add_row(OP_RD_CENT, 0, 0, 0, 0, 1, 64'sh7fff_ffff, 1, ST_OK);
    add_row(OP_RD_CENT, 0, 0, 1, 0, 1, -64'sh8000_0000, 1, ST_OK);
    add_row(OP_ADD, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(OP_RD_SCAT, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_RD_SCAT, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0, 0, 0);
    add_row(OP_RD_SCAT, 0, 0, 3, 2, 0, 0, 0, 0);
    add_row(OP_RD_CENT, 0, 0, 3, 1, 0, 0, 0, 0);
    add_row(OP_CLEAR, 0, 0, 0, 0, 1, 0, 0, ST_OK);
    add_row(OP_RD_SCAT, 0, 0, 1, 1, 1, 0, 0, ST_OK);
    add_row(OP_ADD, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 1, 0, 1, ST_OK);
    add_row(OP_ADD, 32'sh0003_0000, 32'sh0001_0000, 0, 0, 0, 0, 0, 0);
    add_row(OP_RD_SCAT, 0, 0, 0, 1, 0, 0, 0, 0);
    foreach (plan[k]) send_point(plan[k].beat, plan[k].known, plan[k].want);
    drain();

    // dimension 1: out-of-range reads, then zero and above-max codes
    write_dim(3'd1);
    plan.delete();
    add_row(OP_RD_SCAT, 0, 0, 0, 1, 1, 0, 2, ST_RANGE);
    add_row(OP_RD_CENT, 0, 0, 1, 0, 1, 0, 2, ST_RANGE);
    add_row(OP_ADD, -32'sh0002_0000, 5, 0, 0, 0, 0, 0, 0);
    foreach (plan[k]) send_point(plan[k].beat, plan[k].known, plan[k].want);
    drain();
    write_dim(3'd0);
    send_point('{OP_RD_SCAT, 0, 0, 0, 0, 0, 3}, 1, '{0, 3, ST_RANGE});
    drain();
    write_dim(3'd7);
    send_point('{OP_RD_SCAT, 0, 0, 0, 0, 3, 3}, 0, none);
    drain();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 100 == 0) begin
        drain();
        write_dim(3'($urandom_range(7)));
        phase = (k / 100) % 5;
        send_idle_pct = phase == 1 || phase == 3 ? 62 : 0;
        recv_stall_pct = phase == 2 || phase == 3 ? 62 : phase == 4 ? 25 : 0;
        if (phase == 4) send_idle_pct = 25;
      end
      if (k == 550) fork
        begin
          hold_recv = 1;
          repeat (3000) @(posedge clk);
          hold_recv = 0;
        end
      join_none
      b = rand_point();
      send_point(b, 0, none);
      if (k == 800) drain();
    end
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/rsc_pkg.sv
design/running_scatter_covariance.sv
bench/running_scatter_covariance_test.sv
